>>> sv/case_insensitive_substring_finder_macros.svh
// Assertion macros for the case-insensitive substring finder.
// Included by the top-level RTL file, which carries the concurrent checks; no other dependencies.
`ifndef CASE_INSENSITIVE_SUBSTRING_FINDER_MACROS_SVH
`define CASE_INSENSITIVE_SUBSTRING_FINDER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CISF_ASSERT_SAME(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
        else $error("check failed: same-cycle implication");

// next-cycle implication
`define CISF_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
        else $error("check failed: next-cycle implication");

`else

`define CISF_ASSERT_SAME(label, clk, rstn, lhs, rhs)
`define CISF_ASSERT_NEXT(label, clk, rstn, lhs, rhs)

`endif

`endif

>>> sv/cisf_pkg.sv
// Shared types, constants and the ASCII case fold for the substring finder.
// No dependencies.
`default_nettype none

package cisf_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 64;
    localparam int LEN_BITS       = 5;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_index_t;

    // fold A..Z to a..z, everything else unchanged
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            r = c + (ASCII_LOWER_A - ASCII_UPPER_A);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/cisf_cell.sv
// One cell of the match chain: holds the partial-match bit for one pattern position.
// Depends on cisf_pkg (fold_byte).
`default_nettype none

module cisf_cell (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       shift_en,
    input  wire logic       clear,
    input  wire logic [7:0] text_folded,
    input  wire logic [7:0] pattern_byte,
    input  wire logic       prev_match,
    output logic            match_next,
    output logic            match_out
);
    import cisf_pkg::*;

    logic match_reg;

    // pattern prefix up to this position ends at the current text byte
    assign match_next = prev_match && (text_folded == fold_byte(pattern_byte));
    assign match_out  = match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (clear) begin
            match_reg <= 1'b0;
        end else if (shift_en) begin
            match_reg <= match_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/case_insensitive_substring_finder.sv
// Top level of the case-insensitive substring finder: config registers, cell row,
// position tracking and result register. Depends on cisf_pkg, cisf_cell, macros header.
`default_nettype none
`include "case_insensitive_substring_finder_macros.svh"

// Takes one text byte per clock cycle, sustained, with ready held high while the result
// register is empty or being drained. Each byte updates a row of PATTERN_MAX cells;
// cell k keeps whether pattern bytes 0..k (A-Z folded to lower case) end at the latest
// text byte, so the first match is known in the cycle its last byte arrives. On a
// transaction with s_last_byte set, the result (found, start offset of the first match,
// saturation flag) appears registered on the m_ channel in the next cycle and the
// per-text state clears; the next text may begin in the following cycle. A zero byte
// ends the string and later bytes up to the last one are ignored. Offsets beyond
// 2^OFFSET_BITS-1 read as all ones with m_offset_saturated set. Configuration writes
// take effect at once and belong between texts. Reset needs no clearing pass.
module case_insensitive_substring_finder #(
    parameter int PATTERN_MAX = 16,
    parameter int OFFSET_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cisf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [cisf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [7:0]                         s_text_byte,
    input  wire logic                               s_last_byte,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_found,
    output logic [OFFSET_BITS-1:0]                  m_match_offset,
    output logic                                    m_offset_saturated
);
    import cisf_pkg::*;

    localparam int POS_BITS = OFFSET_BITS + 1;

    logic [CFG_DATA_BITS-1:0] pat_low_reg;
    logic [CFG_DATA_BITS-1:0] pat_high_reg;
    logic [LEN_BITS-1:0]      len_reg;

    logic [POS_BITS-1:0]      pos_reg, pos_next;
    logic                     seen_reg, seen_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;
    logic                     sat_reg, sat_next;
    logic                     ended_reg, ended_next;

    logic                     m_valid_reg;
    logic                     found_reg;
    logic [OFFSET_BITS-1:0]   offset_reg;
    logic                     osat_reg;

    logic                     s_accept;
    logic                     take;
    logic                     clear_text;
    logic [7:0]               text_folded;
    logic [2*CFG_DATA_BITS-1:0] pattern_all;
    logic [LEN_BITS-1:0]      len_eff;
    logic [PATTERN_MAX-1:0]   len_onehot;
    logic [PATTERN_MAX-1:0]   match_next_vec;
    logic [PATTERN_MAX-1:0]   match_vec;
    logic                     hit;
    logic [POS_BITS-1:0]      count;
    logic [POS_BITS-1:0]      start_full;
    logic                     start_over;
    logic [OFFSET_BITS-1:0]   start_clip;

    assign s_ready    = !m_valid_reg || m_ready;
    assign s_accept   = s_valid && s_ready;
    assign take       = s_accept && !ended_reg && (s_text_byte != 8'd0);
    assign clear_text = s_accept && s_last_byte;

    assign text_folded = fold_byte(s_text_byte);
    assign pattern_all = {pat_high_reg, pat_low_reg};
    assign len_eff     = (len_reg > LEN_BITS'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX) : len_reg;

    // cell row: each cell hands its partial-match bit to the next one
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic prev;
        if (k == 0) begin : g_first
            assign prev = 1'b1;
        end else begin : g_rest
            assign prev = match_vec[k-1];
        end
        assign len_onehot[k] = (len_eff == LEN_BITS'(k + 1));
        cisf_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .shift_en     (take),
            .clear        (clear_text),
            .text_folded  (text_folded),
            .pattern_byte (pattern_all[8*k +: 8]),
            .prev_match   (prev),
            .match_next   (match_next_vec[k]),
            .match_out    (match_vec[k])
        );
    end

    assign hit = take && !seen_reg && (|(match_next_vec & len_onehot));

    // position after this byte, saturating at all ones
    assign count      = (&pos_reg) ? pos_reg : pos_reg + 1'b1;
    assign start_full = count - POS_BITS'(len_eff);
    assign start_over = start_full[OFFSET_BITS];
    assign start_clip = start_over ? {OFFSET_BITS{1'b1}} : start_full[OFFSET_BITS-1:0];

    always_comb begin
        pos_next   = take ? count : pos_reg;
        seen_next  = seen_reg || hit;
        start_next = hit ? start_clip : start_reg;
        sat_next   = hit ? start_over : sat_reg;
        ended_next = ended_reg || (s_accept && (s_text_byte == 8'd0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                CFG_PATTERN_LENGTH: len_reg      <= cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
            sat_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end else if (clear_text) begin
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
            sat_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
            start_reg <= start_next;
            sat_reg   <= sat_next;
            ended_reg <= ended_next;
        end
    end

    // result register; payload loads with the last transaction of a text
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (clear_text) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear_text) begin
            found_reg  <= seen_next;
            offset_reg <= seen_next ? start_next : '0;
            osat_reg   <= seen_next && sat_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_found            = found_reg;
    assign m_match_offset     = offset_reg;
    assign m_offset_saturated = osat_reg;

    `CISF_ASSERT_SAME(a_notfound_zero, aclk, aresetn, m_valid_reg && !found_reg, (offset_reg == '0) && !osat_reg)
    `CISF_ASSERT_SAME(a_sat_all_ones, aclk, aresetn, m_valid_reg && osat_reg, &offset_reg)
    `CISF_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, clear_text, (pos_reg == '0) && !seen_reg && !ended_reg)
    `CISF_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_ready)
    `CISF_ASSERT_SAME(a_seen_has_bytes, aclk, aresetn, seen_reg, pos_reg != '0)

endmodule

`default_nettype wire
